### sv/lps_pkg.sv
package lps_pkg;

   localparam int COORD_W   = 5;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 1;
   // signed cross-product error; |err| stays below 1024 for 5-bit coordinates
   localparam int ERR_W     = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

### sv/lps_req_if.sv
interface lps_req_if;
   import lps_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] start_row;
   logic [COORD_W-1:0] start_col;
   logic [COORD_W-1:0] end_row;
   logic [COORD_W-1:0] end_col;

   modport source (output valid, start_row, start_col, end_row, end_col, input ready);
   modport sink   (input valid, start_row, start_col, end_row, end_col, output ready);

endinterface

### sv/lps_rsp_if.sv
interface lps_rsp_if;
   import lps_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pix_row;
   logic [COORD_W-1:0] pix_col;
   logic               last;
   logic               rejected;

   modport source (output valid, pix_row, pix_col, last, rejected, input ready);
   modport sink   (input valid, pix_row, pix_col, last, rejected, output ready);

endinterface

### sv/lps_ctrl.sv
module lps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lps_pkg::dp_status_type status,
   output lps_pkg::dp_cmd_type    cmd
);
   import lps_pkg::*;

   typedef enum logic {
      IDLE,
      EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == EMIT);

   always_comb begin
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/lps_dp.sv
module lps_dp #(
   parameter int GRID_MAX = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lps_pkg::CFG_W-1:0]       csr_wdata,
   input  logic [lps_pkg::COORD_W-1:0]     start_row,
   input  logic [lps_pkg::COORD_W-1:0]     start_col,
   input  logic [lps_pkg::COORD_W-1:0]     end_row,
   input  logic [lps_pkg::COORD_W-1:0]     end_col,
   input  lps_pkg::dp_cmd_type             cmd,
   output lps_pkg::dp_status_type          status,
   output logic [lps_pkg::COORD_W-1:0]     pix_row,
   output logic [lps_pkg::COORD_W-1:0]     pix_col,
   output logic                            last,
   output logic                            rejected
);
   import lps_pkg::*;

   localparam int GRID_W = $clog2(GRID_MAX + 1);
   localparam int LIM_W  = (GRID_W > CFG_W + 1) ? GRID_W : CFG_W + 1;

   function automatic logic [ERR_W-2:0] err_mag(input logic signed [ERR_W-1:0] v);
      logic signed [ERR_W-1:0] neg;
      neg = -v;
      return v[ERR_W-1] ? neg[ERR_W-2:0] : v[ERR_W-2:0];
   endfunction

   logic [CFG_W-1:0]   rows_ff;
   logic [CFG_W-1:0]   cols_ff;
   logic [COORD_W-1:0] cur_row_ff;
   logic [COORD_W-1:0] cur_col_ff;
   logic [COORD_W-1:0] end_row_ff;
   logic [COORD_W-1:0] end_col_ff;
   logic [COORD_W-1:0] dr_ff;
   logic [COORD_W-1:0] dc_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic               rej_ff;

   logic [LIM_W-1:0] row_lim;
   logic [LIM_W-1:0] col_lim;
   logic             req_ok;

   logic signed [ERR_W-1:0] dr_ext;
   logic signed [ERR_W-1:0] dc_ext;
   logic signed [ERR_W-1:0] e_s;
   logic signed [ERR_W-1:0] e_w;
   logic signed [ERR_W-1:0] e_d;
   logic [ERR_W-2:0]        m_s;
   logic [ERR_W-2:0]        m_w;
   logic [ERR_W-2:0]        m_d;
   logic                    row_done;
   logic                    col_done;
   logic                    move_row;
   logic                    move_col;

   function automatic logic coord_ok(input logic [COORD_W-1:0] v, input logic [LIM_W-1:0] lim);
      return (v != '0) && ((LIM_W'(v) + LIM_W'(1)) <= lim);
   endfunction

   // grid size clamps to GRID_MAX
   assign row_lim = (LIM_W'(rows_ff) > LIM_W'(GRID_MAX)) ? LIM_W'(GRID_MAX) : LIM_W'(rows_ff);
   assign col_lim = (LIM_W'(cols_ff) > LIM_W'(GRID_MAX)) ? LIM_W'(GRID_MAX) : LIM_W'(cols_ff);

   assign req_ok = coord_ok(start_row, row_lim) && coord_ok(end_row, row_lim)
                && coord_ok(start_col, col_lim) && coord_ok(end_col, col_lim)
                && (start_row <= end_row) && (start_col <= end_col);

   assign dr_ext = $signed({{(ERR_W-COORD_W){1'b0}}, dr_ff});
   assign dc_ext = $signed({{(ERR_W-COORD_W){1'b0}}, dc_ff});

   // error at the three candidate points, from the error at the current one
   assign e_s = err_ff + dc_ext;
   assign e_w = err_ff - dr_ext;
   assign e_d = err_ff + dc_ext - dr_ext;
   assign m_s = err_mag(e_s);
   assign m_w = err_mag(e_w);
   assign m_d = err_mag(e_d);

   assign row_done = (cur_row_ff == end_row_ff);
   assign col_done = (cur_col_ff == end_col_ff);

   always_comb begin
      move_row = 1'b0;
      move_col = 1'b0;
      if (row_done) begin
         move_col = 1'b1;
      end else if (col_done) begin
         move_row = 1'b1;
      end else if ((m_s < m_w) && (m_s <= m_d)) begin
         move_row = 1'b1;
      end else if ((m_w < m_s) && (m_w <= m_d)) begin
         move_col = 1'b1;
      end else begin
         move_row = 1'b1;
         move_col = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= GRID_RESET;
         cols_ff <= GRID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rej_ff <= !req_ok;
         if (req_ok) begin
            cur_row_ff <= start_row;
            cur_col_ff <= start_col;
            end_row_ff <= end_row;
            end_col_ff <= end_col;
            dr_ff      <= end_row - start_row;
            dc_ff      <= end_col - start_col;
            err_ff     <= '0;
         end else begin
            cur_row_ff <= '0;
            cur_col_ff <= '0;
            end_row_ff <= '0;
            end_col_ff <= '0;
         end
      end else if (cmd.step) begin
         if (move_row) begin
            cur_row_ff <= cur_row_ff + COORD_W'(1);
         end
         if (move_col) begin
            cur_col_ff <= cur_col_ff + COORD_W'(1);
         end
         if (move_row && move_col) begin
            err_ff <= e_d;
         end else if (move_row) begin
            err_ff <= e_s;
         end else begin
            err_ff <= e_w;
         end
      end
   end

   assign last        = rej_ff || (row_done && col_done);
   assign rejected    = rej_ff;
   assign pix_row     = cur_row_ff;
   assign pix_col     = cur_col_ff;
   assign status.last = last;

endmodule

### sv/line_pixel_stepper.sv
// The first pixel beat is offered on the cycle after the request beat is taken.
// Throughput: one pixel per cycle while rsp is ready. The single stepping register loop
// in the datapath serves one line at a time: the next request is taken only after the
// last beat.
// Reset: synchronous, active high; returns to idle, rows and cols to 32.
module line_pixel_stepper #(
   parameter int GRID_MAX = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   lps_req_if.sink                       req_bus,
   lps_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [lps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lps_pkg::CFG_W-1:0]     csr_wdata
);
   import lps_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lps_dp #(
      .GRID_MAX (GRID_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .start_row (req_bus.start_row),
      .start_col (req_bus.start_col),
      .end_row   (req_bus.end_row),
      .end_col   (req_bus.end_col),
      .cmd       (cmd),
      .status    (status),
      .pix_row   (rsp_bus.pix_row),
      .pix_col   (rsp_bus.pix_col),
      .last      (rsp_bus.last),
      .rejected  (rsp_bus.rejected)
   );

endmodule

### verif/line_pixel_stepper_tb.sv
module line_pixel_stepper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam int GRID_MAX  = 32;
   localparam int MAX_PIX   = 63;
   localparam int PHASES    = 10;
   localparam int PHASE_LEN = 20;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last;
      logic               rejected;
   } pixel_beat_type;

   typedef struct packed {
      logic [CFG_W-1:0]   g_rows;
      logic [CFG_W-1:0]   g_cols;
      logic [COORD_W-1:0] sr;
      logic [COORD_W-1:0] sc;
      logic [COORD_W-1:0] er;
      logic [COORD_W-1:0] ec;
      logic               typed;
      pixel_beat_type     want;
   } line_case_type;

   localparam pixel_beat_type REJECT_BEAT = '{row: '0, col: '0, last: 1'b1, rejected: 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   lps_req_if req_bus ();
   lps_rsp_if rsp_bus ();

   line_pixel_stepper #(.GRID_MAX(GRID_MAX)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // grid as programmed into the block
   logic [CFG_W-1:0] grid_rows = GRID_RESET;
   logic [CFG_W-1:0] grid_cols = GRID_RESET;

   pixel_beat_type pix_due[$];
   line_case_type  directed_lines[$];
   int             mismatch_count = 0;
   bit             req_idle_on = 1'b1;
   bit             rsp_idle_on = 1'b1;
   bit             rsp_hold_req = 1'b0;

   function automatic bit coord_in_grid(input int v, input int lim);
      if (lim > GRID_MAX) lim = GRID_MAX;
      return v >= 1 && v + 1 <= lim;
   endfunction

   // distance of a candidate point from the ideal line, as a cross product
   function automatic int off_line(input int row_off, input int col_off,
                                   input int dr, input int dc);
      int e;
      e = row_off * dc - col_off * dr;
      return e < 0 ? -e : e;
   endfunction

   function automatic void trace_line(input logic [COORD_W-1:0] sr, sc, er, ec);
      int r, c, dr, dc, go_row, go_col, go_diag, n;
      bit at_end;
      pixel_beat_type px;
      if (!coord_in_grid(sr, grid_rows) || !coord_in_grid(er, grid_rows) ||
          !coord_in_grid(sc, grid_cols) || !coord_in_grid(ec, grid_cols) ||
          sr > er || sc > ec) begin
         pix_due.push_back(REJECT_BEAT);
         return;
      end
      dr = int'(er) - int'(sr);
      dc = int'(ec) - int'(sc);
      r  = sr;
      c  = sc;
      n  = 0;
      while (1) begin
         at_end = (r == er) && (c == ec);
         px = '{row: COORD_W'(r), col: COORD_W'(c), last: at_end, rejected: 1'b0};
         pix_due.push_back(px);
         n++;
         if (at_end || n >= MAX_PIX) break;
         if (r == er) begin
            c++;
         end else if (c == ec) begin
            r++;
         end else begin
            go_row  = off_line(r + 1 - sr, c - sc, dr, dc);
            go_col  = off_line(r - sr, c + 1 - sc, dr, dc);
            go_diag = off_line(r + 1 - sr, c + 1 - sc, dr, dc);
            // row/col tie falls through to the diagonal; diagonal ties lose
            if (go_row < go_col && go_row <= go_diag) begin
               r++;
            end else if (go_col < go_row && go_col <= go_diag) begin
               c++;
            end else begin
               r++;
               c++;
            end
         end
      end
   endfunction

   function automatic line_case_type line_case(input int gr, gc, sr, sc, er, ec,
                                               input int typed, wr, wc, wrej);
      line_case_type lc;
      lc.g_rows        = CFG_W'(gr);
      lc.g_cols        = CFG_W'(gc);
      lc.sr            = COORD_W'(sr);
      lc.sc            = COORD_W'(sc);
      lc.er            = COORD_W'(er);
      lc.ec            = COORD_W'(ec);
      lc.typed         = typed[0];
      lc.want.row      = COORD_W'(wr);
      lc.want.col      = COORD_W'(wc);
      lc.want.last     = 1'b1;
      lc.want.rejected = wrej[0];
      return lc;
   endfunction

   task automatic drain_lines();
      req_bus.valid <= 1'b0;
      while (pix_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_grid(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
      drain_lines();
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= c;
      @(posedge clock);
      csr_we    <= 1'b0;
      grid_rows = r;
      grid_cols = c;
   endtask

   task automatic send_line(input line_case_type lc);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.start_row <= lc.sr;
      req_bus.start_col <= lc.sc;
      req_bus.end_row   <= lc.er;
      req_bus.end_col   <= lc.ec;
      do @(posedge clock); while (!req_bus.ready);
      if (lc.typed) pix_due.push_back(lc.want);
      else trace_line(lc.sr, lc.sc, lc.er, lc.ec);
   endtask

   task automatic pick_line(output line_case_type lc);
      int rl, cl, kind;
      logic [COORD_W-1:0] t;
      lc = '0;
      rl = (int'(grid_rows) > GRID_MAX) ? GRID_MAX : int'(grid_rows);
      cl = (int'(grid_cols) > GRID_MAX) ? GRID_MAX : int'(grid_cols);
      kind = $urandom_range(0, 9);
      if (kind == 9 || rl < 2 || cl < 2) begin
         lc.sr = COORD_W'($urandom);
         lc.sc = COORD_W'($urandom);
         lc.er = COORD_W'($urandom);
         lc.ec = COORD_W'($urandom);
      end else begin
         lc.sr = COORD_W'($urandom_range(1, rl - 1));
         lc.er = COORD_W'($urandom_range(int'(lc.sr), rl - 1));
         lc.sc = COORD_W'($urandom_range(1, cl - 1));
         lc.ec = COORD_W'($urandom_range(int'(lc.sc), cl - 1));
         if (kind >= 7) begin
            case ($urandom_range(0, 3))
               0: begin
                  t = lc.sr; lc.sr = lc.er; lc.er = t;
               end
               1: begin
                  t = lc.sc; lc.sc = lc.ec; lc.ec = t;
               end
               2: lc.sc = '0;
               // one past the grid edge; wraps to zero on a full grid
               default: lc.er = COORD_W'(rl);
            endcase
         end
      end
   endtask

   initial begin : stimulus
      line_case_type lc;
      logic [CFG_W-1:0] gr, gc;
      req_bus.valid     <= 1'b0;
      req_bus.start_row <= '0;
      req_bus.start_col <= '0;
      req_bus.end_row   <= '0;
      req_bus.end_col   <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_ROWS;
      csr_wdata         <= '0;
      //                         grid    start   end     typed row col rej
      directed_lines = {
         line_case(32, 32,  1,  1,  1,  1,  1,  1,  1, 0),
         line_case(32, 32, 31, 31, 31, 31,  1, 31, 31, 0),
         line_case(32, 32,  1,  1, 31, 31,  0,  0,  0, 0),
         line_case(32, 32,  1,  1, 31,  1,  0,  0,  0, 0),
         line_case(32, 32,  1,  1,  1, 31,  0,  0,  0, 0),
         line_case(32, 32,  1,  1, 31, 30,  0,  0,  0, 0),
         line_case(32, 32,  1,  1,  3,  2,  0,  0,  0, 0),
         line_case(32, 32,  2,  3,  4,  9,  0,  0,  0, 0),
         line_case(32, 32,  3,  2, 10,  5,  0,  0,  0, 0),
         line_case(32, 32,  0,  5,  3,  6,  1,  0,  0, 1),
         line_case(32, 32,  5,  0,  6,  3,  1,  0,  0, 1),
         line_case(32, 32,  5,  5,  4,  6,  1,  0,  0, 1),
         line_case(32, 32,  5,  5,  6,  4,  1,  0,  0, 1),
         line_case(32, 32,  0,  0,  0,  0,  1,  0,  0, 1),
         line_case(63, 63, 31, 31, 31, 31,  1, 31, 31, 0),
         line_case(63, 63,  1,  2, 31, 20,  0,  0,  0, 0),
         line_case( 2,  2,  1,  1,  1,  1,  1,  1,  1, 0),
         line_case( 2,  2,  1,  1,  1,  2,  1,  0,  0, 1),
         line_case( 1,  1,  1,  1,  1,  1,  1,  0,  0, 1),
         line_case( 0,  0,  5,  5,  6,  6,  1,  0,  0, 1),
         line_case(32, 16,  1, 15, 20, 15,  0,  0,  0, 0),
         line_case(32, 16,  1, 16,  2, 16,  1,  0,  0, 1),
         line_case(16, 32, 15, 31, 15, 31,  1, 15, 31, 0),
         line_case(16, 32, 16,  1, 16,  1,  1,  0,  0, 1)
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_lines[i]) begin
         if (directed_lines[i].g_rows != grid_rows || directed_lines[i].g_cols != grid_cols)
            write_grid(directed_lines[i].g_rows, directed_lines[i].g_cols);
         send_line(directed_lines[i]);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin gr = 6'd32; gc = 6'd32; end
            1: begin gr = 6'd63; gc = 6'd63; end
            2: begin gr = 6'd2;  gc = CFG_W'($urandom_range(2, 63)); end
            3: begin gr = CFG_W'($urandom_range(2, 63)); gc = 6'd2; end
            // a grid under two rows refuses every line
            4: begin gr = CFG_W'($urandom_range(0, 1)); gc = CFG_W'($urandom_range(0, 63)); end
            default: begin
               gr = CFG_W'($urandom_range(8, 63));
               gc = CFG_W'($urandom_range(8, 63));
            end
         endcase
         write_grid(gr, gc);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < PHASE_LEN; k++) begin
            pick_line(lc);
            send_line(lc);
            if (ph == 5 && k == 3) rsp_hold_req = 1'b1;
         end
      end

      drain_lines();
      repeat (70) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // pixel sink: random stalls per beat, plus one long hold-off
   initial begin : pix_sink
      int gap;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         gap = rsp_idle_on ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin : pix_check
      pixel_beat_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{row: rsp_bus.pix_row, col: rsp_bus.pix_col,
                 last: rsp_bus.last, rejected: rsp_bus.rejected};
         if (pix_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat: expected none, %s %0d col %0d last %0b rej %0b",
                     $time, "actual row", got.row, got.col, got.last, got.rejected);
         end else begin
            want = pix_due.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.last !== want.last || got.rejected !== want.rejected) begin
               mismatch_count++;
               $display({"%0t: expected row %0d col %0d last %0b rej %0b, ",
                         "actual row %0d col %0d last %0b rej %0b"},
                        $time, want.row, want.col, want.last, want.rejected,
                        got.row, got.col, got.last, got.rejected);
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
